@@ hdl/first_fit_block_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

@@ hdl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS     = 32;
    localparam int HEADER_BYTES   = 24;
    localparam int POOL_ADDR_BITS = 20;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W = POOL_ADDR_BITS + 1;

    // fixed field widths
    localparam int REQ_W    = 21;
    localparam int OFF_W    = 20;
    localparam int POOL_W   = 21;
    localparam int STATUS_W = 2;

    localparam int ALU_W = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic [POOL_ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]         size;
        logic                      free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             borrow;
        logic             zero;
    } alu_rsp_t;

endpackage

`default_nettype wire

@@ hdl/ffba_alu.sv @@
// ----------------------------------------------------------------------------
// ffba_alu
// Shared add/subtract unit with borrow and zero flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_alu
    import ffba_pkg::*;
(
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [ALU_W:0]   full;
    logic [ALU_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign full = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.sum    = full[ALU_W-1:0];
    assign rsp.borrow = req.sub & ~full[ALU_W];
    assign rsp.zero   = (full[ALU_W-1:0] == '0);

endmodule

`default_nettype wire

@@ hdl/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a configurable pool, with block split and free coalesce.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | tuser: func; tdata: request_size, block_offset
// m_*     | out | m_tvalid/m_tready  | tdata: payload_offset, status
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: pool_bytes
//
// One beat at a time: s_tready and cfg_ready are high only while the sequencer
// is idle. Allocate scans the block table one entry at a time through the
// one RAM read port; a split moves the entries above the fit up by one.
// Free scans the same way, then rewrites the table in one coalescing pass
// that merges each run of free blocks. After reset or a pool_bytes write,
// the S_INIT state rebuilds the first block. A waiting result sits in the
// output register; the next beat is accepted meanwhile, and a new result
// holds in the sequencer until the old one drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave side
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // request_size[20:0], block_offset[40:21]
    input  wire logic                 s_tuser,   // func[0]
    // master side
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // payload_offset[19:0], status[21:20]
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [POOL_W-1:0]    cfg_data
);

    typedef enum logic [17:0] {
        S_INIT   = 18'h00001,
        S_IDLE   = 18'h00002,
        S_PREP   = 18'h00004,
        S_RD     = 18'h00008,
        S_CHK    = 18'h00010,
        S_FIT    = 18'h00020,
        S_SHRD   = 18'h00040,
        S_SHWR   = 18'h00080,
        S_NEWS   = 18'h00100,
        S_NEWZ   = 18'h00200,
        S_WCUR   = 18'h00400,
        S_OUTOFF = 18'h00800,
        S_MRD    = 18'h01000,
        S_MCHK   = 18'h02000,
        S_MADD1  = 18'h04000,
        S_MADD2  = 18'h08000,
        S_MFIN   = 18'h10000,
        S_DONE   = 18'h20000
    } state_t;

    localparam logic [ALU_W-1:0]  HDR_A      = ALU_W'(HEADER_BYTES);
    localparam logic [ALU_W-1:0]  POOL_LIMIT = ALU_W'(1) << POOL_ADDR_BITS;
    localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_BLOCKS);
    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(65536);

    state_t state_reg, state_next;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    logic                      func_reg, func_next;
    logic [REQ_W-1:0]          req_reg, req_next;
    logic [OFF_W-1:0]          off_reg, off_next;
    logic [ALU_W-1:0]          tmp_reg, tmp_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          w_reg, w_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          hit_reg, hit_next;
    entry_t                    ent_reg, ent_next;
    entry_t                    acc_reg, acc_next;
    logic [POOL_ADDR_BITS-1:0] ns_reg, ns_next;
    logic                      split_reg, split_next;
    logic [OFF_W-1:0]          res_off_reg, res_off_next;
    logic [STATUS_W-1:0]       res_st_reg, res_st_next;
    logic [OFF_W-1:0]          out_off_reg, out_off_next;
    logic [STATUS_W-1:0]       out_st_reg, out_st_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_bits;
    entry_t           rd_ent;
    entry_t           mrg_ent;
    logic [ALU_W-1:0] pool_ext;
    logic [ALU_W-1:0] pool_sat;

    assign rd_ent = entry_t'(rd_bits);

    ffba_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    // saturate the pool to the addressable range
    assign pool_ext = ALU_W'(pool_reg);
    assign pool_sat = (pool_ext > POOL_LIMIT) ? POOL_LIMIT : pool_ext;

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - OFF_W - STATUS_W){1'b0}}, out_st_reg, out_off_reg};

    always_comb
    begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        tmp_next       = tmp_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        hit_next       = hit_reg;
        ent_next       = ent_reg;
        acc_next       = acc_reg;
        ns_next        = ns_reg;
        split_next     = split_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && !m_tready;

        alu_req  = '0;
        wr_en    = 1'b0;
        wr_addr  = idx_reg[IDX_W-1:0];
        wr_data  = acc_reg;
        rd_addr  = idx_reg[IDX_W-1:0];
        mrg_ent  = rd_ent;
        if (idx_reg == hit_reg)
        begin
            mrg_ent.free = 1'b1;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // rebuild the table as one free block
                alu_req.a   = pool_sat;
                alu_req.b   = HDR_A;
                alu_req.sub = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data.start = '0;
                wr_data.size  = (alu_rsp.borrow || alu_rsp.zero) ? '0
                                                                 : alu_rsp.sum[SIZE_W-1:0];
                wr_data.free  = 1'b1;
                count_next    = CNT_ONE;
                state_next    = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    pool_next  = cfg_data;
                    state_next = S_INIT;
                end
                else if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    req_next   = s_tdata[REQ_W-1:0];
                    off_next   = s_tdata[REQ_W +: OFF_W];
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // allocate: request plus header; free: offset less header
                idx_next = '0;
                if (func_reg == FUNC_ALLOC)
                begin
                    alu_req.a  = ALU_W'(req_reg);
                    alu_req.b  = HDR_A;
                    tmp_next   = alu_rsp.sum;
                    state_next = S_RD;
                end
                else
                begin
                    alu_req.a   = ALU_W'(off_reg);
                    alu_req.b   = HDR_A;
                    alu_req.sub = 1'b1;
                    tmp_next    = alu_rsp.sum;
                    if (alu_rsp.borrow)
                    begin
                        res_off_next = '0;
                        res_st_next  = ST_BADFREE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    res_off_next = '0;
                    res_st_next  = (func_reg == FUNC_ALLOC) ? ST_NOFIT : ST_BADFREE;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                ent_next = rd_ent;
                if (func_reg == FUNC_ALLOC)
                begin
                    alu_req.a   = ALU_W'(rd_ent.size);
                    alu_req.b   = ALU_W'(req_reg);
                    alu_req.sub = 1'b1;
                    if (rd_ent.free && !alu_rsp.borrow)
                    begin
                        state_next = S_FIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_ONE;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    alu_req.a   = ALU_W'(rd_ent.start);
                    alu_req.b   = tmp_reg;
                    alu_req.sub = 1'b1;
                    if (alu_rsp.zero)
                    begin
                        if (rd_ent.free)
                        begin
                            res_off_next = '0;
                            res_st_next  = ST_BADFREE;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            hit_next   = idx_reg;
                            idx_next   = '0;
                            w_next     = '0;
                            state_next = S_MRD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_ONE;
                        state_next = S_RD;
                    end
                end
            end
            S_FIT:
            begin
                // split only when the remainder exceeds a header and a slot is left
                alu_req.a   = ALU_W'(ent_reg.size);
                alu_req.b   = tmp_reg;
                alu_req.sub = 1'b1;
                split_next  = !alu_rsp.borrow && !alu_rsp.zero && (count_reg != CNT_MAX);
                k_next      = count_reg;
                state_next  = (!alu_rsp.borrow && !alu_rsp.zero && (count_reg != CNT_MAX))
                              ? S_SHRD : S_WCUR;
            end
            S_SHRD:
            begin
                // move entries above the split point up by one
                if (k_reg > idx_reg + CNT_ONE)
                begin
                    rd_addr    = IDX_W'(k_reg - CNT_ONE);
                    state_next = S_SHWR;
                end
                else
                begin
                    state_next = S_NEWS;
                end
            end
            S_SHWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[IDX_W-1:0];
                wr_data    = rd_ent;
                k_next     = k_reg - CNT_ONE;
                state_next = S_SHRD;
            end
            S_NEWS:
            begin
                alu_req.a  = ALU_W'(ent_reg.start);
                alu_req.b  = tmp_reg;
                ns_next    = alu_rsp.sum[POOL_ADDR_BITS-1:0];
                state_next = S_NEWZ;
            end
            S_NEWZ:
            begin
                alu_req.a     = ALU_W'(ent_reg.size);
                alu_req.b     = tmp_reg;
                alu_req.sub   = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = IDX_W'(idx_reg + CNT_ONE);
                wr_data.start = ns_reg;
                wr_data.size  = alu_rsp.sum[SIZE_W-1:0];
                wr_data.free  = 1'b1;
                state_next    = S_WCUR;
            end
            S_WCUR:
            begin
                wr_en         = 1'b1;
                wr_data.start = ent_reg.start;
                wr_data.size  = split_reg ? SIZE_W'(req_reg) : ent_reg.size;
                wr_data.free  = 1'b0;
                if (split_reg)
                begin
                    count_next = count_reg + CNT_ONE;
                end
                state_next = S_OUTOFF;
            end
            S_OUTOFF:
            begin
                alu_req.a    = ALU_W'(ent_reg.start);
                alu_req.b    = HDR_A;
                res_off_next = alu_rsp.sum[OFF_W-1:0];
                res_st_next  = ST_OK;
                state_next   = S_DONE;
            end
            S_MRD:
            begin
                state_next = (idx_reg >= count_reg) ? S_MFIN : S_MCHK;
            end
            S_MCHK:
            begin
                // coalesce runs of free blocks while compacting the table
                ent_next = mrg_ent;
                if (idx_reg == '0)
                begin
                    acc_next   = mrg_ent;
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = S_MRD;
                end
                else if (acc_reg.free && mrg_ent.free)
                begin
                    state_next = S_MADD1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = w_reg[IDX_W-1:0];
                    wr_data    = acc_reg;
                    w_next     = w_reg + CNT_ONE;
                    acc_next   = mrg_ent;
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = S_MRD;
                end
            end
            S_MADD1:
            begin
                alu_req.a     = ALU_W'(acc_reg.size);
                alu_req.b     = HDR_A;
                acc_next.size = alu_rsp.sum[SIZE_W-1:0];
                state_next    = S_MADD2;
            end
            S_MADD2:
            begin
                alu_req.a     = ALU_W'(acc_reg.size);
                alu_req.b     = ALU_W'(ent_reg.size);
                acc_next.size = alu_rsp.sum[SIZE_W-1:0];
                idx_next      = idx_reg + CNT_ONE;
                state_next    = S_MRD;
            end
            S_MFIN:
            begin
                wr_en        = 1'b1;
                wr_addr      = w_reg[IDX_W-1:0];
                wr_data      = acc_reg;
                count_next   = w_reg + CNT_ONE;
                res_off_next = '0;
                res_st_next  = ST_OK;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pool_reg      <= POOL_RESET;
            count_reg     <= CNT_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        req_reg     <= req_next;
        off_reg     <= off_next;
        tmp_reg     <= tmp_next;
        idx_reg     <= idx_next;
        w_reg       <= w_next;
        k_reg       <= k_next;
        hit_reg     <= hit_next;
        ent_reg     <= ent_next;
        acc_reg     <= acc_next;
        ns_reg      <= ns_next;
        split_reg   <= split_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
    end

endmodule

`default_nettype wire

@@ hdl/ffba_checker.sv @@
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_block_allocator_unit_assert.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result must hold
    `FFBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one beat at a time: the sequencer is busy right after an accept
    `FFBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a failed request never reports an offset
    `FFBA_ASSERT_NOW(a_fail_zero_offset, m_tvalid && (m_tdata[21:20] != ST_OK),
                     m_tdata[19:0] == '0)

    // status code stays within the defined codes
    `FFBA_ASSERT_NOW(a_status_code, m_tvalid,
                     (m_tdata[21:20] == ST_OK) || (m_tdata[21:20] == ST_NOFIT) ||
                     (m_tdata[21:20] == ST_BADFREE))

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/tb_first_fit_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// Self-checking bench for the first-fit allocator. Keeps its own copy of the
// block table and predicts offset and status per beat. Pool size is changed
// between phases. Both sides idle at random, and one long output stall is run.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct packed {
        logic [OFF_W-1:0]    offset;
        logic [STATUS_W-1:0] status;
    } alloc_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // request_size[20:0], block_offset[40:21]
    logic                 s_tuser = 1'b0; // func[0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // payload_offset[19:0], status[21:20]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [POOL_W-1:0]    cfg_data = '0;

    // shadow block table
    logic [OFF_W-1:0]  tbl_start [MAX_BLOCKS];
    logic [SIZE_W-1:0] tbl_size  [MAX_BLOCKS];
    logic              tbl_free  [MAX_BLOCKS];
    int                tbl_count;
    logic [OFF_W-1:0]  live_offsets [$];   // offsets currently allocated

    alloc_reply_t pending_replies [$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  failed = 1'b0;

    first_fit_block_allocator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Rebuild the table as one free block covering the pool less one header.
    function automatic void table_rebuild(logic [POOL_W-1:0] pool);
        longint p;
        p = pool;
        if (p > (64'd1 << POOL_ADDR_BITS))
            p = 64'd1 << POOL_ADDR_BITS;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_free[i]  = 1'b0;
        end
        tbl_size[0] = (p > HEADER_BYTES) ? SIZE_W'(p - HEADER_BYTES) : '0;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
        live_offsets.delete();
    endfunction

    function automatic void table_drop(int idx);
        for (int k = idx; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_size[k]  = tbl_size[k + 1];
            tbl_free[k]  = tbl_free[k + 1];
        end
        tbl_count--;
    endfunction

    function automatic alloc_reply_t predict_reply(logic func, logic [REQ_W-1:0] req,
                                                    logic [OFF_W-1:0] off);
        alloc_reply_t r;
        longint sz;
        int i;
        r.offset = '0;
        if (func == FUNC_ALLOC)
        begin
            r.status = ST_NOFIT;
            for (i = 0; i < tbl_count; i++)
            begin
                sz = tbl_size[i];
                if (tbl_free[i] && sz >= req)
                begin
                    if (sz > longint'(req) + HEADER_BYTES && tbl_count < MAX_BLOCKS)
                    begin
                        for (int k = tbl_count; k > i + 1; k--)
                        begin
                            tbl_start[k] = tbl_start[k - 1];
                            tbl_size[k]  = tbl_size[k - 1];
                            tbl_free[k]  = tbl_free[k - 1];
                        end
                        tbl_start[i + 1] = OFF_W'(tbl_start[i] + HEADER_BYTES + req);
                        tbl_size[i + 1]  = SIZE_W'(sz - req - HEADER_BYTES);
                        tbl_free[i + 1]  = 1'b1;
                        tbl_size[i]      = SIZE_W'(req);
                        tbl_count++;
                    end
                    tbl_free[i] = 1'b0;
                    r.offset = OFF_W'(tbl_start[i] + HEADER_BYTES);
                    r.status = ST_OK;
                    live_offsets.push_back(r.offset);
                    break;
                end
            end
        end
        else
        begin
            r.status = ST_BADFREE;
            for (i = 0; i < tbl_count; i++)
            begin
                if (longint'(tbl_start[i]) + HEADER_BYTES == off)
                begin
                    if (!tbl_free[i])
                    begin
                        tbl_free[i] = 1'b1;
                        r.status = ST_OK;
                        // coalesce every run of adjacent free blocks
                        i = 0;
                        while (i + 1 < tbl_count)
                        begin
                            if (tbl_free[i] && tbl_free[i + 1])
                            begin
                                tbl_size[i] = SIZE_W'(tbl_size[i] + HEADER_BYTES
                                                      + tbl_size[i + 1]);
                                table_drop(i + 1);
                            end
                            else
                                i++;
                        end
                        foreach (live_offsets[j])
                            if (live_offsets[j] == off)
                            begin
                                live_offsets.delete(j);
                                break;
                            end
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    // Random gap: mostly none or short, a few long.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(20, 120);
        repeat (n) @(negedge clk);
    endtask

    // Send one beat and record its expected reply.
    task automatic send_request(logic func, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
        alloc_reply_t r;
        s_tuser  <= func;
        s_tdata  <= {7'd0, off, req};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_reply(func, req, off);
        pending_replies.push_back(r);
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(negedge clk);
        // allow the sequencer to finish its coalescing pass
        repeat (300) @(negedge clk);
    endtask

    task automatic write_pool(logic [POOL_W-1:0] pool);
        wait_drained();
        cfg_data  <= pool;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        table_rebuild(pool);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (2) @(negedge clk);
    endtask

    task automatic free_random_live();
        int j;
        logic [OFF_W-1:0] off;
        j = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[j];
        send_request(FUNC_FREE, '0, off);
    endtask

    // Edges of the fields, zero-byte and oversize requests, bad frees, table fill.
    task automatic test_directed();
        send_request(FUNC_ALLOC, 21'd0, '0);
        send_request(FUNC_ALLOC, 21'h1FFFFF, '0);
        send_request(FUNC_ALLOC, 21'd100, 20'hFFFFF);
        send_request(FUNC_FREE, 21'h1FFFFF, 20'hFFFFF);
        send_request(FUNC_FREE, '0, 20'd0);
        send_request(FUNC_FREE, '0, 20'd24);
        send_request(FUNC_FREE, '0, 20'd24);
        send_request(FUNC_ALLOC, 21'd65512, '0);
        send_request(FUNC_ALLOC, 21'd1, '0);
        write_pool(21'd64);
        send_request(FUNC_ALLOC, 21'd40, '0);
        send_request(FUNC_ALLOC, 21'd0, '0);
        send_request(FUNC_FREE, '0, 20'd24);
        // below one header: first block has zero payload
        write_pool(21'd10);
        send_request(FUNC_ALLOC, 21'd0, '0);
        send_request(FUNC_ALLOC, 21'd1, '0);
        // above the address space: saturated
        write_pool(21'h1FFFFF);
        send_request(FUNC_ALLOC, 21'd1048552, '0);
        send_request(FUNC_FREE, '0, 20'd24);
        // fill the table so the last fit is handed out whole
        for (int i = 0; i < 33; i++)
            send_request(FUNC_ALLOC, 21'd8, '0);
        write_pool(21'd65536);
    endtask

    task automatic test_random(int count, int max_req);
        logic [OFF_W-1:0] off;
        for (int i = 0; i < count; i++)
        begin
            idle_gap();
            if ($urandom_range(0, 99) < 50 || live_offsets.size() == 0)
                send_request(FUNC_ALLOC, REQ_W'($urandom_range(0, max_req)),
                             OFF_W'($urandom));
            else if ($urandom_range(0, 9) < 8)
                free_random_live();
            else
            begin
                off = ($urandom_range(0, 1) != 0) ? OFF_W'($urandom)
                                                  : live_offsets[0] + OFF_W'(1);
                send_request(FUNC_FREE, REQ_W'($urandom), off);
            end
        end
    endtask

    // Hold the receiver off while requests keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            test_random(20, 500);
        join
    endtask

    // Result checker; also drives m_tready.
    initial
    begin
        alloc_reply_t exp_r;
        alloc_reply_t got;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.offset = m_tdata[19:0];
                got.status = m_tdata[21:20];
                if (pending_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected reply: offset %0d status %0d",
                                 got.offset, got.status);
                end
                else
                begin
                    exp_r = pending_replies.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("reply mismatch: exp off %0d st %0d, got off %0d st %0d",
                                     exp_r.offset, exp_r.status, got.offset, got.status);
                    end
                end
            end
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Watchdog: count cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        table_rebuild(21'd65536);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);
        test_directed();
        test_random(350, 4000);
        test_backpressure();
        write_pool(21'd1024);
        test_random(250, 120);
        write_pool(21'd1048576);
        test_random(250, 70000);
        wait_drained();
        failed = (mismatch_count != 0) || (pending_replies.size() != 0);
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_alu.sv
hdl/ffba_ram.sv
hdl/first_fit_block_allocator_unit.sv
hdl/ffba_checker.sv
tb/sv/tb_first_fit_block_allocator_unit.sv
